### rtl/core/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, codes and helpers for the status frame conditioner.
// ----------------------------------------------------------------------------
package sfc_pkg;

    // field widths
    localparam int SALT_W   = 16;
    localparam int RAW_W    = 4;
    localparam int HEALTH_W = 4;
    localparam int THR_W    = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // item function codes
    localparam logic FUNC_STATUS     = 1'b0;
    localparam logic FUNC_COMMS_LOST = 1'b1;

    // raw status codes with special meaning
    localparam logic [RAW_W-1:0] RAW_OFF         = 4'd1;
    localparam logic [RAW_W-1:0] RAW_TURNING_OFF = 4'd2;
    localparam logic [RAW_W-1:0] RAW_LAST_KNOWN  = 4'd11;

    // health codes
    localparam logic [HEALTH_W-1:0] HEALTH_OK          = 4'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_TURNING_OFF = 4'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_UNKNOWN     = 4'd11;

    // configuration register indexes
    localparam logic REG_RAISE_FRAMES = 1'b0;
    localparam logic REG_CLEAR_FRAMES = 1'b1;

    // configuration reset values and the dwell count limit
    localparam logic [THR_W-1:0] RAISE_FRAMES_RST = 8'd2;
    localparam logic [THR_W-1:0] CLEAR_FRAMES_RST = 8'd5;
    localparam logic [THR_W-1:0] PCOUNT_MAX       = 8'd255;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic in_comms;
        logic found;
        logic out_free;
    } t_status;

    // raw status to health code
    function automatic logic [HEALTH_W-1:0] map_health(input logic [RAW_W-1:0] raw);
        logic [HEALTH_W-1:0] h;
        if (raw <= RAW_OFF) begin
            h = HEALTH_OK;
        end else if (raw == RAW_TURNING_OFF) begin
            h = HEALTH_TURNING_OFF;
        end else if (raw <= RAW_LAST_KNOWN) begin
            h = raw - 4'd1;
        end else begin
            h = HEALTH_UNKNOWN;
        end
        return h;
    endfunction

    function automatic logic is_concerning(input logic [HEALTH_W-1:0] h);
        return !(h == HEALTH_OK || h == HEALTH_TURNING_OFF);
    endfunction

endpackage

### rtl/core/sfc_item_if.sv
// ----------------------------------------------------------------------------
// sfc_item_if
// Input channel carrying one status frame transaction.
// ----------------------------------------------------------------------------
interface sfc_item_if import sfc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              func;
    logic [RAW_W-1:0]  raw_status;
    logic [SALT_W-1:0] salt_sample;

    modport source (output valid, output func, output raw_status, output salt_sample,
                    input ready);
    modport sink   (input valid, input func, input raw_status, input salt_sample,
                    output ready);

endinterface

### rtl/core/sfc_result_if.sv
// ----------------------------------------------------------------------------
// sfc_result_if
// Output channel carrying one conditioned result transaction.
// ----------------------------------------------------------------------------
interface sfc_result_if import sfc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                salt_valid;
    logic [SALT_W-1:0]   salt_median;
    logic                health_valid;
    logic [HEALTH_W-1:0] health;
    logic                chlorinator_on;

    modport source (output valid, output salt_valid, output salt_median,
                    output health_valid, output health, output chlorinator_on,
                    input ready);
    modport sink   (input valid, input salt_valid, input salt_median,
                    input health_valid, input health, input chlorinator_on,
                    output ready);

endinterface

### rtl/core/status_frame_conditioner_unit.sv
// ----------------------------------------------------------------------------
// status_frame_conditioner_unit
// Median salt smoothing and debounced health reporting for status frames.
// ----------------------------------------------------------------------------
// Flow: a status frame is taken in S_IDLE, then the one-slot-per-cycle rank search
//   in S_SEARCH stops at slot j (0..WINDOW_SIZE-1), and S_DONE loads the result
//   once the output register is free; a comms-lost transaction skips S_SEARCH.
// Handshake: one transaction at a time; a new frame is
//   taken while the previous result still waits in the output register.
// Reset: synchronous active low; clears window bookkeeping, dwell state, output
//   valid and thresholds (raise 2, clear 5); window contents are not cleared.
module status_frame_conditioner_unit import sfc_pkg::*; #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sfc_item_if.sink          i_item,
    sfc_result_if.source      o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [THR_W-1:0] r_raise_frames;
    logic [THR_W-1:0] r_clear_frames;
    logic             w_reg_idx;
    t_cmd             w_cmd;
    t_status          w_status;

    // configuration registers
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raise_frames <= RAISE_FRAMES_RST;
            r_clear_frames <= CLEAR_FRAMES_RST;
        end else if (psel && penable && pwrite) begin
            if (w_reg_idx == REG_RAISE_FRAMES) begin
                r_raise_frames <= pwdata[THR_W-1:0];
            end else begin
                r_clear_frames <= pwdata[THR_W-1:0];
            end
        end
    end

    assign prdata = (w_reg_idx == REG_RAISE_FRAMES) ? APB_DW'(r_raise_frames)
                                                    : APB_DW'(r_clear_frames);

    // sequencer
    sfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // datapath
    sfc_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_raise_frames (r_raise_frames),
        .i_clear_frames (r_clear_frames),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_item         (i_item),
        .o_result       (o_result)
    );

    // one frame at a time: no new transaction right after one is taken
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("input taken again straight after a transaction");

    // a result is only loaded into a free output register
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("result overwrote a pending transaction");

    // a result without salt is a comms-lost report
    a_comms_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.salt_valid |->
            o_result.health_valid && o_result.health == HEALTH_UNKNOWN &&
            !o_result.chlorinator_on && o_result.salt_median == '0)
        else $error("malformed comms-lost result");

    // the rank search only steps while a frame is in hand
    a_search_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> !w_cmd.in_ready)
        else $error("search step while idle");

endmodule

### rtl/core/sfc_ctrl.sv
// ----------------------------------------------------------------------------
// sfc_ctrl
// Sequencer: takes a frame, steps the median rank search, hands off the result.
// ----------------------------------------------------------------------------
module sfc_ctrl import sfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.in_comms ? S_DONE : S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_status.found) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/sfc_datapath.sv
// ----------------------------------------------------------------------------
// sfc_datapath
// Salt window with rank search, dwell debouncer and the output register.
// ----------------------------------------------------------------------------
module sfc_datapath import sfc_pkg::*; #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [THR_W-1:0]   i_raise_frames,
    input  logic [THR_W-1:0]   i_clear_frames,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    sfc_item_if.sink           i_item,
    sfc_result_if.source       o_result
);

    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

    // window and its bookkeeping
    logic [SALT_W-1:0] r_win [WINDOW_SIZE];
    logic [IDX_W-1:0]  r_widx, n_widx;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]  r_cand;

    // dwell state
    logic                r_started, n_started;
    logic [HEALTH_W-1:0] r_shown, n_shown;
    logic [HEALTH_W-1:0] r_pending, n_pending;
    logic [THR_W-1:0]    r_pcount, n_pcount;

    // result being built
    logic                r_salt_valid;
    logic [SALT_W-1:0]   r_smooth;
    logic                r_hvalid, n_hvalid;
    logic [HEALTH_W-1:0] r_health, n_health;
    logic                r_on;

    // output register
    logic                r_out_valid;
    logic                r_o_salt_valid;
    logic [SALT_W-1:0]   r_o_smooth;
    logic                r_o_hvalid;
    logic [HEALTH_W-1:0] r_o_health;
    logic                r_o_on;

    logic                w_is_comms;
    logic [HEALTH_W-1:0] w_raw_h;
    logic [THR_W-1:0]    w_cnt_new;
    logic [THR_W-1:0]    w_thr;
    logic [SALT_W-1:0]   w_cand_val;
    logic [WINDOW_SIZE-1:0] w_lt_mask, w_le_mask;
    logic [CNT_W-1:0]    w_lt, w_le, w_rank;

    assign w_is_comms = (i_item.func == FUNC_COMMS_LOST);
    assign w_raw_h    = map_health(i_item.raw_status);

    // status towards the controller
    assign i_item.ready      = i_cmd.in_ready;
    assign o_status.in_valid = i_item.valid;
    assign o_status.in_comms = w_is_comms;
    assign o_status.out_free = !r_out_valid || o_result.ready;

    // ring index and fill count
    always_comb begin
        n_widx = r_widx;
        n_fill = r_fill;
        if (i_cmd.load) begin
            if (w_is_comms) begin
                n_widx = '0;
                n_fill = '0;
            end else begin
                n_widx = (r_widx == IDX_W'(WINDOW_SIZE - 1)) ? '0 : r_widx + 1'b1;
                if (r_fill != CNT_W'(WINDOW_SIZE)) begin
                    n_fill = r_fill + 1'b1;
                end
            end
        end
    end

    // dwell debouncer
    always_comb begin
        n_started = r_started;
        n_shown   = r_shown;
        n_pending = r_pending;
        n_pcount  = r_pcount;
        n_hvalid  = 1'b0;
        n_health  = HEALTH_OK;
        w_cnt_new = (w_raw_h == r_pending) ?
                    ((r_pcount == PCOUNT_MAX) ? r_pcount : r_pcount + 1'b1) : THR_W'(1);
        w_thr     = (is_concerning(r_shown) && !is_concerning(w_raw_h)) ?
                    i_clear_frames : i_raise_frames;
        if (w_is_comms) begin
            n_started = 1'b0;
            n_pcount  = '0;
            n_hvalid  = 1'b1;
            n_health  = HEALTH_UNKNOWN;
        end else if (w_raw_h != HEALTH_UNKNOWN) begin
            if (!r_started) begin
                n_started = 1'b1;
                n_shown   = w_raw_h;
                n_pending = w_raw_h;
                n_pcount  = '0;
                n_hvalid  = 1'b1;
                n_health  = w_raw_h;
            end else if (w_raw_h == r_shown) begin
                n_pending = w_raw_h;
                n_pcount  = '0;
            end else begin
                n_pending = w_raw_h;
                if (w_cnt_new >= w_thr) begin
                    n_shown  = w_raw_h;
                    n_pcount = '0;
                    n_hvalid = 1'b1;
                    n_health = w_raw_h;
                end else begin
                    n_pcount = w_cnt_new;
                end
            end
        end
    end

    // rank of the current candidate among the filled entries
    assign w_cand_val = r_win[r_cand];
    always_comb begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            w_lt_mask[i] = (i < int'(r_fill)) && (r_win[i] <  w_cand_val);
            w_le_mask[i] = (i < int'(r_fill)) && (r_win[i] <= w_cand_val);
        end
    end
    assign w_lt           = CNT_W'($countones(w_lt_mask));
    assign w_le           = CNT_W'($countones(w_le_mask));
    assign w_rank         = r_fill >> 1;
    assign o_status.found = (w_lt <= w_rank) && (w_le > w_rank);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx      <= '0;
            r_fill      <= '0;
            r_started   <= 1'b0;
            r_shown     <= HEALTH_OK;
            r_pending   <= HEALTH_OK;
            r_pcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_widx <= n_widx;
            r_fill <= n_fill;
            if (i_cmd.load) begin
                r_started <= n_started;
                r_shown   <= n_shown;
                r_pending <= n_pending;
                r_pcount  <= n_pcount;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window write, search candidate and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!w_is_comms) begin
                r_win[r_widx] <= i_item.salt_sample;
            end
            r_cand       <= '0;
            r_salt_valid <= !w_is_comms;
            r_smooth     <= '0;
            r_hvalid     <= n_hvalid;
            r_health     <= n_health;
            r_on         <= !(w_is_comms || i_item.raw_status == RAW_OFF ||
                              i_item.raw_status == RAW_TURNING_OFF);
        end else if (i_cmd.step) begin
            if (o_status.found) begin
                r_smooth <= w_cand_val;
            end else begin
                r_cand <= r_cand + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_o_salt_valid <= r_salt_valid;
            r_o_smooth     <= r_smooth;
            r_o_hvalid     <= r_hvalid;
            r_o_health     <= r_health;
            r_o_on         <= r_on;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.salt_valid     = r_o_salt_valid;
    assign o_result.salt_median    = r_o_smooth;
    assign o_result.health_valid   = r_o_hvalid;
    assign o_result.health         = r_o_health;
    assign o_result.chlorinator_on = r_o_on;

endmodule

### tb/sv/tb_status_frame_conditioner_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_status_frame_conditioner_unit
// Self-checking bench for the status frame conditioner. A local model of the
// salt median window and the health dwell debouncer predicts one report per
// accepted frame transaction. Reports are compared field by field in order.
// Traffic is a directed set of corner frames followed by random status runs
// shaped around the dwell thresholds, under several threshold settings,
// with bursty input, random output stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_status_frame_conditioner_unit;
    import sfc_pkg::*;

    localparam int WIN        = 5;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 250;

    // raw status codes not named in the package
    localparam logic [RAW_W-1:0] RAW_ON        = 4'd0;
    localparam logic [RAW_W-1:0] RAW_WARN_LO   = 4'd3;
    localparam logic [RAW_W-1:0] RAW_CHECK_PCB = 4'd10;
    localparam logic [RAW_W-1:0] RAW_FAULT     = 4'd11;
    localparam logic [RAW_W-1:0] RAW_UNK_LO    = 4'd12;
    localparam logic [RAW_W-1:0] RAW_UNK_HI    = 4'd15;

    // register byte addresses
    localparam logic [APB_AW-1:0] ADDR_RAISE = {REG_RAISE_FRAMES, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_CLEAR = {REG_CLEAR_FRAMES, 2'b00};

    typedef struct packed {
        logic                salt_valid;
        logic [SALT_W-1:0]   salt_median;
        logic                health_valid;
        logic [HEALTH_W-1:0] health;
        logic                chlorinator_on;
    } t_report;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sfc_item_if   item_ch ();
    sfc_result_if result_ch ();

    status_frame_conditioner_unit #(
        .WINDOW_SIZE(WIN)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model state and thresholds
    logic [SALT_W-1:0]   salt_ring [WIN];
    int unsigned         ring_wr;
    int unsigned         ring_fill;
    bit                  dwell_started;
    logic [HEALTH_W-1:0] shown_code;
    logic [HEALTH_W-1:0] candidate_code;
    logic [THR_W-1:0]    candidate_run;
    logic [THR_W-1:0]    raise_thr;
    logic [THR_W-1:0]    clear_thr;

    t_report predicted_reports [$];

    // bench control
    int  tx_burst_max;
    int  tx_gap_max;
    int  tx_burst_left;
    bit  tx_held;
    int  rx_stall_pct;
    int  rx_stall_left;
    int  rx_hold_request;
    int  rx_hold_left;

    // run statistics
    int error_count;
    int frames_sent;
    int comms_sent;
    int reports_checked;
    int health_updates;
    int thr_writes;
    int holds_seen;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic [HEALTH_W-1:0] status_to_health(input logic [RAW_W-1:0] code);
        if (code <= RAW_OFF) begin
            return HEALTH_OK;
        end else if (code == RAW_TURNING_OFF) begin
            return HEALTH_TURNING_OFF;
        end else if (code <= RAW_LAST_KNOWN) begin
            return code - 4'd1;
        end
        return HEALTH_UNKNOWN;
    endfunction

    function automatic bit is_benign(input logic [HEALTH_W-1:0] h);
        return (h == HEALTH_OK) || (h == HEALTH_TURNING_OFF);
    endfunction

    // upper median of the filled slots
    function automatic logic [SALT_W-1:0] ring_median();
        logic [SALT_W-1:0] sorted [WIN];
        logic [SALT_W-1:0] v;
        int                j;
        for (int i = 0; i < ring_fill; i++) begin
            v = salt_ring[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[ring_fill / 2];
    endfunction

    function automatic t_report predict_report(input logic func, input logic [RAW_W-1:0] raw,
                                               input logic [SALT_W-1:0] salt);
        t_report             r;
        logic [HEALTH_W-1:0] h;
        logic [THR_W-1:0]    thr;
        r = '0;
        if (func == FUNC_COMMS_LOST) begin
            ring_wr        = 0;
            ring_fill      = 0;
            dwell_started  = 1'b0;
            candidate_run  = '0;
            r.health_valid = 1'b1;
            r.health       = HEALTH_UNKNOWN;
            return r;
        end
        // window update and median
        salt_ring[ring_wr] = salt;
        ring_wr = (ring_wr + 1) % WIN;
        if (ring_fill < WIN) ring_fill++;
        r.salt_valid     = 1'b1;
        r.salt_median    = ring_median();
        r.chlorinator_on = !(raw == RAW_OFF || raw == RAW_TURNING_OFF);
        // dwell debounce
        h = status_to_health(raw);
        if (h == HEALTH_UNKNOWN) begin
            return r;
        end
        if (!dwell_started) begin
            dwell_started  = 1'b1;
            shown_code     = h;
            candidate_code = h;
            candidate_run  = '0;
            r.health_valid = 1'b1;
            r.health       = h;
        end else if (h == shown_code) begin
            candidate_code = h;
            candidate_run  = '0;
        end else begin
            if (h == candidate_code) begin
                if (candidate_run != PCOUNT_MAX) candidate_run++;
            end else begin
                candidate_code = h;
                candidate_run  = 8'd1;
            end
            thr = (!is_benign(shown_code) && is_benign(h)) ? clear_thr : raise_thr;
            if (candidate_run >= thr) begin
                shown_code     = h;
                candidate_run  = '0;
                r.health_valid = 1'b1;
                r.health       = h;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // report checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s wrong, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (predicted_reports.size() == 0) begin
                $display("%0t: stray report, expected none, actual salt %0d health %0d",
                         $time, result_ch.salt_median, result_ch.health);
                error_count++;
            end else begin
                want = predicted_reports.pop_front();
                check_field("salt_valid", want.salt_valid, result_ch.salt_valid);
                check_field("salt_median", want.salt_median, result_ch.salt_median);
                check_field("health_valid", want.health_valid, result_ch.health_valid);
                check_field("health", want.health, result_ch.health);
                check_field("chlorinator_on", want.chlorinator_on, result_ch.chlorinator_on);
                reports_checked++;
                if (want.health_valid) health_updates++;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------

    initial result_ch.ready = 1'b0;

    always @(negedge i_clk) begin
        if (rx_hold_request > 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
            holds_seen++;
        end
        if (rx_hold_left > 0) begin
            result_ch.ready <= 1'b0;
            rx_hold_left--;
        end else if (rx_stall_left > 0) begin
            result_ch.ready <= 1'b0;
            rx_stall_left--;
        end else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
            result_ch.ready <= 1'b0;
            rx_stall_left = $urandom_range(0, 5);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles with no transaction on any port
    // ------------------------------------------------------------------

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // frame sender
    // ------------------------------------------------------------------

    // one frame transaction; returns at a falling edge
    task automatic send_frame(input logic func, input logic [RAW_W-1:0] raw,
                              input logic [SALT_W-1:0] salt);
        int gap;
        if (!tx_held) @(negedge i_clk);
        item_ch.valid       <= 1'b1;
        item_ch.func        <= func;
        item_ch.raw_status  <= raw;
        item_ch.salt_sample <= salt;
        do @(posedge i_clk); while (!item_ch.ready);
        predicted_reports.push_back(predict_report(func, raw, salt));
        frames_sent++;
        if (func == FUNC_COMMS_LOST) comms_sent++;
        @(negedge i_clk);
        if (tx_gap_max == 0 || tx_burst_left > 0) begin
            if (tx_burst_left > 0) tx_burst_left--;
            tx_held = 1'b1;
        end else begin
            item_ch.valid <= 1'b0;
            tx_held       = 1'b0;
            tx_burst_left = $urandom_range(0, tx_burst_max);
            gap           = $urandom_range(0, tx_gap_max);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // drop valid when a burst ends early; called at the sender's falling edge
    task automatic tx_release();
        if (tx_held) begin
            item_ch.valid <= 1'b0;
            tx_held = 1'b0;
        end
    endtask

    task automatic wait_reports_drained();
        tx_release();
        while (predicted_reports.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // register access
    // ------------------------------------------------------------------

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [APB_AW-1:0] addr, input logic [THR_W-1:0] want);
        logic [APB_DW-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", want, got[THR_W-1:0]);
    endtask

    // thresholds change only with the block idle
    task automatic set_thresholds(input logic [THR_W-1:0] raise, input logic [THR_W-1:0] clr);
        wait_reports_drained();
        repeat (2 * WIN + 4) @(posedge i_clk);
        apb_write(ADDR_RAISE, {{(APB_DW-THR_W){1'b0}}, raise});
        raise_thr = raise;
        apb_write(ADDR_CLEAR, {{(APB_DW-THR_W){1'b0}}, clr});
        clear_thr = clr;
        thr_writes += 2;
        apb_read_check(ADDR_RAISE, raise);
        apb_read_check(ADDR_CLEAR, clr);
    endtask

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------

    function automatic logic [SALT_W-1:0] rand_salt();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SALT_W'(16'd3000 + $urandom_range(0, 3));
            default: return SALT_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] rand_known_status();
        if ($urandom_range(0, 99) < 40)
            return RAW_W'($urandom_range(RAW_ON, RAW_TURNING_OFF));
        return RAW_W'($urandom_range(RAW_WARN_LO, RAW_FAULT));
    endfunction

    // runs of one status sized around the thresholds, with noise and breaks
    task automatic stream_status_runs(input int count);
        int               sent;
        int               sel;
        int               len;
        int               thr;
        int               lo;
        logic [RAW_W-1:0] raw;
        sent = 0;
        while (sent < count) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                send_frame(FUNC_COMMS_LOST, RAW_W'($urandom), SALT_W'($urandom));
                sent++;
            end else if (sel < 16) begin
                len = $urandom_range(1, 6);
                repeat (len) send_frame(FUNC_STATUS, RAW_W'($urandom_range(0, 15)),
                                        rand_salt());
                sent += len;
            end else begin
                raw = rand_known_status();
                thr = $urandom_range(0, 1) ? raise_thr : clear_thr;
                lo  = (thr > 1) ? thr - 1 : 1;
                len = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(lo, thr + 1);
                for (int i = 0; i < len; i++) begin
                    // long runs only see unknown frames, short ones any break
                    if ($urandom_range(0, 19) == 0) begin
                        if (len > 20)
                            send_frame(FUNC_STATUS,
                                       RAW_W'($urandom_range(RAW_UNK_LO, RAW_UNK_HI)),
                                       rand_salt());
                        else
                            send_frame(FUNC_STATUS, RAW_W'($urandom_range(0, 15)),
                                       rand_salt());
                        sent++;
                    end
                    send_frame(FUNC_STATUS, raw, rand_salt());
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_register_access();
        set_thresholds(8'd255, 8'd255);
        set_thresholds(8'd1, 8'd1);
        set_thresholds(RAISE_FRAMES_RST, CLEAR_FRAMES_RST);
    endtask

    task automatic test_directed_cases();
        tx_burst_max = 3;
        tx_gap_max   = 4;
        rx_stall_pct = 20;
        // unknown before any known reading: ignored
        send_frame(FUNC_STATUS, RAW_UNK_LO, 16'h0000);
        // first known reading shown at once
        send_frame(FUNC_STATUS, RAW_ON, 16'hFFFF);
        // off agrees with shown ok
        send_frame(FUNC_STATUS, RAW_OFF, 16'h0001);
        // raise to turning off after two frames
        send_frame(FUNC_STATUS, RAW_TURNING_OFF, 16'h8000);
        send_frame(FUNC_STATUS, RAW_TURNING_OFF, 16'h7FFF);
        // raise to fault, the window wraps on the first of these frames
        send_frame(FUNC_STATUS, RAW_FAULT, 16'h0000);
        send_frame(FUNC_STATUS, RAW_FAULT, 16'hFFFF);
        // clear to benign needs the clear count
        repeat (5) send_frame(FUNC_STATUS, RAW_ON, 16'h1234);
        // warning raise, then switch to check pcb across an unknown frame
        send_frame(FUNC_STATUS, RAW_WARN_LO, 16'h00FF);
        send_frame(FUNC_STATUS, RAW_WARN_LO, 16'hFF00);
        send_frame(FUNC_STATUS, RAW_CHECK_PCB, 16'h5555);
        send_frame(FUNC_STATUS, RAW_UNK_HI, 16'hAAAA);
        send_frame(FUNC_STATUS, RAW_CHECK_PCB, 16'h5555);
        // pending change dropped when reading returns to shown health
        send_frame(FUNC_STATUS, RAW_CHECK_PCB - 4'd1, 16'h0F0F);
        send_frame(FUNC_STATUS, RAW_CHECK_PCB, 16'hF0F0);
        send_frame(FUNC_STATUS, RAW_CHECK_PCB - 4'd1, 16'h0F0F);
        // comms lost with junk payload, then a fresh first reading
        send_frame(FUNC_COMMS_LOST, RAW_UNK_HI, 16'hFFFF);
        send_frame(FUNC_STATUS, RAW_WARN_LO + 4'd2, 16'h0000);
        // zero raise threshold and minimum clear threshold
        set_thresholds(8'd0, 8'd1);
        send_frame(FUNC_STATUS, RAW_WARN_LO + 4'd1, 16'h0042);
        send_frame(FUNC_STATUS, RAW_ON, 16'h0043);
        send_frame(FUNC_STATUS, RAW_WARN_LO + 4'd1, 16'h0044);
    endtask

    task automatic test_mixed_traffic();
        set_thresholds(8'd3, 8'd7);
        tx_burst_max = 8;
        tx_gap_max   = 10;
        rx_stall_pct = 25;
        stream_status_runs(250);
        // sender waits for every report before going on
        wait_reports_drained();
        stream_status_runs(250);
    endtask

    task automatic test_receiver_hold();
        set_thresholds(8'd2, 8'd3);
        tx_gap_max      = 0;
        rx_stall_pct    = 0;
        rx_hold_request = HOLD_LEN;
        stream_status_runs(80);
        wait_reports_drained();
    endtask

    task automatic test_fast_thresholds();
        set_thresholds(8'd1, 8'd1);
        tx_gap_max   = 0;
        rx_stall_pct = 0;
        stream_status_runs(150);
        tx_burst_max = 2;
        tx_gap_max   = 3;
        rx_stall_pct = 40;
        stream_status_runs(150);
    endtask

    task automatic test_slow_raise();
        set_thresholds(8'd255, 8'd4);
        tx_burst_max = 12;
        tx_gap_max   = 6;
        rx_stall_pct = 15;
        stream_status_runs(500);
    endtask

    task automatic test_slow_clear();
        set_thresholds(8'd6, 8'd255);
        tx_burst_max = 5;
        tx_gap_max   = 8;
        rx_stall_pct = 30;
        stream_status_runs(450);
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        item_ch.valid       = 1'b0;
        item_ch.func        = FUNC_STATUS;
        item_ch.raw_status  = RAW_ON;
        item_ch.salt_sample = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_rst_n         = 1'b0;
        tx_burst_max    = 4;
        tx_gap_max      = 4;
        tx_burst_left   = 0;
        tx_held         = 1'b0;
        rx_stall_pct    = 0;
        rx_stall_left   = 0;
        rx_hold_request = 0;
        rx_hold_left    = 0;
        error_count     = 0;
        frames_sent     = 0;
        comms_sent      = 0;
        reports_checked = 0;
        health_updates  = 0;
        thr_writes      = 0;
        holds_seen      = 0;
        ring_wr         = 0;
        ring_fill       = 0;
        dwell_started   = 1'b0;
        shown_code      = HEALTH_OK;
        candidate_code  = HEALTH_OK;
        candidate_run   = '0;
        raise_thr       = RAISE_FRAMES_RST;
        clear_thr       = CLEAR_FRAMES_RST;
        for (int i = 0; i < WIN; i++) salt_ring[i] = '0;

        // reset
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_directed_cases();
        test_mixed_traffic();
        test_receiver_hold();
        test_fast_thresholds();
        test_slow_raise();
        test_slow_clear();

        // drain and settle
        wait_reports_drained();
        repeat (4 * WIN + 8) @(posedge i_clk);
        if (predicted_reports.size() != 0) begin
            $display("%0t: %0d reports never arrived", $time, predicted_reports.size());
            error_count++;
        end

        $display("covered %0d frame transactions (%0d comms lost), %0d reports checked",
                 frames_sent, comms_sent, reports_checked);
        $display("%0d health updates, %0d threshold writes, %0d long output hold-offs",
                 health_updates, thr_writes, holds_seen);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/sfc_pkg.sv
rtl/core/sfc_item_if.sv
rtl/core/sfc_result_if.sv
rtl/core/sfc_ctrl.sv
rtl/core/sfc_datapath.sv
rtl/core/status_frame_conditioner_unit.sv
tb/sv/tb_status_frame_conditioner_unit.sv
